[sv/cppc_pkg.sv]
// cppc_pkg: shared types and constants of the convex polygon plane clipper
// depends on nothing; used by cppc_ctrl, cppc_datapath and the top level
`timescale 1ns / 1ps
`default_nettype none
package cppc_pkg;

    localparam int COORD_W = 32;
    localparam int NORM_W  = 32;
    localparam int OFFS_W  = 48;
    // signed plane distance, Q16.16; magnitude stays below 2^48
    localparam int DIST_W  = 50;
    localparam int FRAC_W  = 30;
    localparam int T_W     = FRAC_W + 1;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_SIDE = 3'd4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_DEGEN    = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_DIST,
        ST_ROUTE,
        ST_EDGE,
        ST_DIV_START,
        ST_DIV,
        ST_LERP_MUL,
        ST_LERP_ADD,
        ST_PUSH_X,
        ST_PUSH_V,
        ST_EDGE_END,
        ST_COMMIT,
        ST_FINAL,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic capture;
        logic prod;
        logic dist_calc;
        logic commit;
        logic div_start;
        logic div_step;
        logic lerp_mul;
        logic lerp_add;
        logic push_cross;
        logic push_vert;
        logic finalize;
        logic flush;
        logic edge_sel;   // 0: prior to current, 1: current to first
    } cmd_t;

    typedef struct packed {
        logic fin;
        logic seen_first;
        logic degen;
        logic a_neg;
        logic b_neg;
        logic div_done;
        logic k_last;
        logic push_ok;
        logic pend_valid;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

[sv/cppc_ctrl.sv]
// cppc_ctrl: sequencer of one vertex transaction through the clip datapath
// depends on cppc_pkg
`timescale 1ns / 1ps
`default_nettype none
module cppc_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire cppc_pkg::stat_t stat,
    output cppc_pkg::cmd_t       cmd
);

    cppc_pkg::state_t state_reg, state_next;
    logic edge_reg, edge_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cppc_pkg::ST_IDLE;
            edge_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            edge_reg  <= edge_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        edge_next  = edge_reg;
        unique case (state_reg)
            cppc_pkg::ST_IDLE:      if (in_valid) state_next = cppc_pkg::ST_PROD;
            cppc_pkg::ST_PROD:      state_next = cppc_pkg::ST_DIST;
            cppc_pkg::ST_DIST:      state_next = cppc_pkg::ST_ROUTE;
            cppc_pkg::ST_ROUTE: begin
                edge_next = 1'b0;
                priority if (stat.fin && stat.degen) state_next = cppc_pkg::ST_FINAL;
                else if (stat.seen_first)            state_next = cppc_pkg::ST_COMMIT;
                else                                 state_next = cppc_pkg::ST_EDGE;
            end
            cppc_pkg::ST_EDGE: begin
                priority if (stat.a_neg ^ stat.b_neg) state_next = cppc_pkg::ST_DIV_START;
                else if (!stat.b_neg)                 state_next = cppc_pkg::ST_PUSH_V;
                else                                  state_next = cppc_pkg::ST_EDGE_END;
            end
            cppc_pkg::ST_DIV_START: state_next = cppc_pkg::ST_DIV;
            cppc_pkg::ST_DIV:       if (stat.div_done) state_next = cppc_pkg::ST_LERP_MUL;
            cppc_pkg::ST_LERP_MUL:  state_next = cppc_pkg::ST_LERP_ADD;
            cppc_pkg::ST_LERP_ADD:
                state_next = stat.k_last ? cppc_pkg::ST_PUSH_X : cppc_pkg::ST_LERP_MUL;
            cppc_pkg::ST_PUSH_X: begin
                if (stat.push_ok)
                    state_next = stat.b_neg ? cppc_pkg::ST_EDGE_END : cppc_pkg::ST_PUSH_V;
            end
            cppc_pkg::ST_PUSH_V:    if (stat.push_ok) state_next = cppc_pkg::ST_EDGE_END;
            cppc_pkg::ST_EDGE_END: begin
                priority if (edge_reg) state_next = cppc_pkg::ST_FINAL;
                else if (stat.fin) begin
                    edge_next  = 1'b1;
                    state_next = cppc_pkg::ST_EDGE;
                end else state_next = cppc_pkg::ST_COMMIT;
            end
            cppc_pkg::ST_COMMIT:    state_next = cppc_pkg::ST_FLUSH;
            cppc_pkg::ST_FINAL:     state_next = cppc_pkg::ST_FLUSH;
            cppc_pkg::ST_FLUSH: begin
                if (!stat.pend_valid || stat.out_free) state_next = cppc_pkg::ST_IDLE;
            end
            default:                state_next = cppc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd          = '0;
        cmd.edge_sel = edge_reg;
        in_ready     = 1'b0;
        unique case (state_reg)
            cppc_pkg::ST_IDLE: begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            cppc_pkg::ST_PROD:      cmd.prod = 1'b1;
            cppc_pkg::ST_DIST:      cmd.dist_calc = 1'b1;
            cppc_pkg::ST_DIV_START: cmd.div_start = 1'b1;
            cppc_pkg::ST_DIV:       cmd.div_step = !stat.div_done;
            cppc_pkg::ST_LERP_MUL:  cmd.lerp_mul = 1'b1;
            cppc_pkg::ST_LERP_ADD:  cmd.lerp_add = 1'b1;
            cppc_pkg::ST_PUSH_X:    cmd.push_cross = stat.push_ok;
            cppc_pkg::ST_PUSH_V:    cmd.push_vert = stat.push_ok;
            cppc_pkg::ST_COMMIT:    cmd.commit = 1'b1;
            cppc_pkg::ST_FINAL:     cmd.finalize = 1'b1;
            cppc_pkg::ST_FLUSH:     cmd.flush = 1'b1;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[sv/cppc_datapath.sv]
// cppc_datapath: plane distance, crossing divider and interpolator, record
// staging and output register; depends on cppc_pkg
`timescale 1ns / 1ps
`default_nettype none
module cppc_datapath #(
    parameter int MAX_VERTS = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [cppc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cppc_pkg::OFFS_W-1:0]       cfg_data,
    input  wire logic [3*cppc_pkg::COORD_W-1:0]    in_data,
    input  wire logic                              in_last,
    input  wire cppc_pkg::cmd_t                    cmd,
    output cppc_pkg::stat_t                        stat,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [3*cppc_pkg::COORD_W-1:0]         m_data,
    output logic                                   m_last,
    output logic [2:0]                             m_user
);

    localparam int CW = cppc_pkg::COORD_W;
    localparam int DW = cppc_pkg::DIST_W;
    localparam int FW = cppc_pkg::FRAC_W;
    localparam int TW = cppc_pkg::T_W;
    localparam int EMIT_W = $clog2(MAX_VERTS + 1);
    localparam int PW = TW + 1 + CW + 1;

    typedef logic signed [CW-1:0] coord_t;

    // configuration
    logic signed [cppc_pkg::NORM_W-1:0] nx_reg, ny_reg, nz_reg;
    logic signed [cppc_pkg::OFFS_W-1:0] offs_reg;
    logic keep_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nx_reg   <= '0;
            ny_reg   <= '0;
            nz_reg   <= 32'sd1073741824;
            offs_reg <= '0;
            keep_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                cppc_pkg::CFG_NORMAL_X:  nx_reg <= cfg_data[cppc_pkg::NORM_W-1:0];
                cppc_pkg::CFG_NORMAL_Y:  ny_reg <= cfg_data[cppc_pkg::NORM_W-1:0];
                cppc_pkg::CFG_NORMAL_Z:  nz_reg <= cfg_data[cppc_pkg::NORM_W-1:0];
                cppc_pkg::CFG_OFFSET:    offs_reg <= cfg_data;
                cppc_pkg::CFG_KEEP_SIDE: keep_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // payload registers
    coord_t cur_reg [3];
    coord_t first_reg [3];
    coord_t prior_reg [3];
    coord_t cross_reg [3];
    logic signed [DW-1:0] cur_d_reg, first_d_reg, prior_d_reg;
    logic signed [2*CW-1:0] px_reg, py_reg, pz_reg;
    logic fin_reg;
    logic [1:0] seen_reg;
    logic [EMIT_W-1:0] emitted_reg;
    logic ovf_reg;

    // divider and interpolator
    logic [DW:0]   rem_reg;
    logic [TW-1:0] q_reg;
    logic [4:0]    cnt_reg;
    logic [1:0]    k_reg;
    logic signed [PW-1:0] lp_reg;

    // pending record and output register
    coord_t pend_reg [3];
    logic pend_valid_reg, pend_present_reg, pend_eop_reg;
    logic [1:0] pend_status_reg;
    coord_t out_reg [3];
    logic out_valid_reg, out_present_reg, out_eop_reg;
    logic [1:0] out_status_reg;

    // edge endpoints
    coord_t a_pt [3];
    coord_t b_pt [3];
    logic signed [DW-1:0] da, db;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_pt[i] = cmd.edge_sel ? cur_reg[i] : prior_reg[i];
            b_pt[i] = cmd.edge_sel ? first_reg[i] : cur_reg[i];
        end
        da = cmd.edge_sel ? cur_d_reg : prior_d_reg;
        db = cmd.edge_sel ? first_d_reg : cur_d_reg;
    end

    // distance sum, products floored to Q16.16
    logic signed [DW-1:0] dsum, dval;
    always_comb begin
        dsum = DW'($signed(px_reg[2*CW-1:FW])) + DW'($signed(py_reg[2*CW-1:FW]))
             + DW'($signed(pz_reg[2*CW-1:FW])) - DW'(offs_reg);
        dval = keep_reg ? -dsum : dsum;
    end

    // divider operands
    logic signed [DW:0] ddiff;
    logic [DW-1:0] num, den;
    logic [DW:0] rem_sh;
    always_comb begin
        ddiff  = (DW+1)'(da) - (DW+1)'(db);
        num    = da[DW-1] ? DW'(-da) : DW'(da);
        den    = ddiff[DW] ? DW'(-ddiff) : DW'(ddiff);
        rem_sh = {rem_reg[DW-1:0], 1'b0};
    end

    logic signed [CW:0] lerp_diff;
    assign lerp_diff = (CW+1)'(b_pt[k_reg]) - (CW+1)'(a_pt[k_reg]);

    logic out_free, emit_full, out_load;
    assign out_free  = !out_valid_reg || m_ready;
    assign emit_full = emitted_reg >= EMIT_W'(MAX_VERTS);
    // pending record moves to the output register
    assign out_load  = pend_valid_reg &&
                       (((cmd.push_cross || cmd.push_vert) && !emit_full) ||
                        (cmd.flush && out_free));

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cur_reg[0] <= in_data[CW-1:0];
            cur_reg[1] <= in_data[2*CW-1:CW];
            cur_reg[2] <= in_data[3*CW-1:2*CW];
            fin_reg    <= in_last;
        end
        if (cmd.prod) begin
            px_reg <= nx_reg * cur_reg[0];
            py_reg <= ny_reg * cur_reg[1];
            pz_reg <= nz_reg * cur_reg[2];
        end
        if (cmd.dist_calc) cur_d_reg <= dval;
        if (cmd.commit) begin
            if (seen_reg == 2'd1) begin
                first_reg   <= cur_reg;
                first_d_reg <= cur_d_reg;
            end
            prior_reg   <= cur_reg;
            prior_d_reg <= cur_d_reg;
        end
        if (cmd.div_start) begin
            k_reg <= 2'd0;
            if ((DW+1)'(num) == (DW+1)'(den)) begin
                q_reg   <= TW'(1) << FW;
                cnt_reg <= 5'd0;
            end else begin
                q_reg   <= '0;
                rem_reg <= (DW+1)'(num);
                cnt_reg <= 5'(FW);
            end
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg - 5'd1;
            if (rem_sh >= (DW+1)'(den)) begin
                rem_reg <= rem_sh - (DW+1)'(den);
                q_reg   <= {q_reg[TW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[TW-2:0], 1'b0};
            end
        end
        if (cmd.lerp_mul) lp_reg <= PW'($signed({1'b0, q_reg}) * lerp_diff);
        if (cmd.lerp_add) begin
            cross_reg[k_reg] <= a_pt[k_reg] + coord_t'(lp_reg[FW+CW-1:FW]);
            k_reg <= k_reg + 2'd1;
        end
    end

    // record staging, counters and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg       <= '0;
            emitted_reg    <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            if (cmd.capture && seen_reg != 2'd3) seen_reg <= seen_reg + 2'd1;
            if (cmd.push_cross || cmd.push_vert) begin
                if (emit_full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    emitted_reg <= emitted_reg + EMIT_W'(1);
                    if (pend_valid_reg) begin
                        out_reg         <= pend_reg;
                        out_present_reg <= pend_present_reg;
                        out_eop_reg     <= pend_eop_reg;
                        out_status_reg  <= pend_status_reg;
                    end
                    pend_reg         <= cmd.push_cross ? cross_reg : b_pt;
                    pend_valid_reg   <= 1'b1;
                    pend_present_reg <= 1'b1;
                    pend_eop_reg     <= 1'b0;
                    pend_status_reg  <= cppc_pkg::STATUS_OK;
                end
            end
            if (cmd.finalize) begin
                if (!pend_valid_reg) begin
                    pend_reg         <= '{default: '0};
                    pend_present_reg <= 1'b0;
                end
                pend_valid_reg  <= 1'b1;
                pend_eop_reg    <= 1'b1;
                pend_status_reg <= (seen_reg < 2'd3) ? cppc_pkg::STATUS_DEGEN :
                                   ovf_reg ? cppc_pkg::STATUS_OVERFLOW : cppc_pkg::STATUS_OK;
                seen_reg    <= '0;
                emitted_reg <= '0;
                ovf_reg     <= 1'b0;
            end
            if (cmd.flush && pend_valid_reg && out_free) begin
                out_reg         <= pend_reg;
                out_present_reg <= pend_present_reg;
                out_eop_reg     <= pend_eop_reg;
                out_status_reg  <= pend_status_reg;
                pend_valid_reg  <= 1'b0;
            end
        end
    end

    always_comb begin
        stat.fin        = fin_reg;
        stat.seen_first = seen_reg == 2'd1;
        stat.degen      = seen_reg < 2'd3;
        stat.a_neg      = da[DW-1];
        stat.b_neg      = db[DW-1];
        stat.div_done   = cnt_reg == 5'd0;
        stat.k_last     = k_reg == 2'd2;
        stat.push_ok    = !pend_valid_reg || out_free;
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = out_free;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = {out_reg[2], out_reg[1], out_reg[0]};
    assign m_last  = out_eop_reg;
    assign m_user  = {out_status_reg, out_present_reg};

endmodule
`default_nettype wire

[sv/convex_polygon_plane_clip.sv]
// convex_polygon_plane_clip: top level of the streaming half-space polygon clipper
// depends on cppc_pkg, cppc_ctrl and cppc_datapath
`timescale 1ns / 1ps
`default_nettype none
// Clips a convex 3D polygon against one plane, one vertex per input
// transaction, Sutherland-Hodgman style. Each vertex gets a signed distance
// d = side * (n . p - offset) in Q16.16; d >= 0 is inside. For every edge the
// block sends the crossing point (when the edge crosses) and then the end
// vertex (when inside); the closing edge back to the first vertex is handled
// after the vertex flagged by tlast, so the output is a rotation of the
// textbook polygon. The last record of a polygon carries tlast and the clip
// status. A vertex is taken only while the block is idle. Per vertex the
// block forms the products and the distance, then works the edge from the
// prior vertex (not for the first vertex of a polygon nor for a degenerate
// closing vertex). A crossing point loads the one-bit-per-cycle divider,
// which forms the 30-bit crossing fraction (skipped when the edge ends
// exactly on the plane), then the shared multiplier interpolates x, y and z
// in turn, and the record is staged. The closing vertex also works the edge
// back to the first vertex with that edge's records and crossing. A stalled
// result port holds the block at its next record. The plane registers may
// be written only while no polygon is in flight through the block.
module convex_polygon_plane_clip #(
    parameter int MAX_VERTS = 32   // output vertex limit per polygon, 4 to 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration write port
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [47:0]  cfg_data,
    // vertex input
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [95:0]  s_axis_tdata,  // vert_x, vert_y, vert_z
    input  wire logic         s_axis_tlast,  // final_vertex
    // clipped polygon output
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [95:0]       m_axis_tdata,  // out_x, out_y, out_z
    output logic              m_axis_tlast,  // end_of_polygon
    output logic [2:0]        m_axis_tuser   // vertex_present, clip_status[1:0]
);

    cppc_pkg::cmd_t  cmd;
    cppc_pkg::stat_t stat;

    // sequencer for one vertex transaction
    cppc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // distance, divider, interpolator and output staging
    cppc_datapath #(
        .MAX_VERTS (MAX_VERTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_axis_tdata),
        .m_last    (m_axis_tlast),
        .m_user    (m_axis_tuser)
    );

`ifndef ASSERT_OFF
    // status-only records only close a polygon
    a_status_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("status-only record without end of polygon");

    // a status code shows only on the closing record
    a_status_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser[2:1] == cppc_pkg::STATUS_OK))
        else $error("clip status on a non-final record");

    // unused status code never appears
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser[2:1] != 2'd3))
        else $error("invalid clip status");

    // one vertex at a time: no transaction in the cycle after one is taken
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("vertex accepted while busy");
`endif

endmodule
`default_nettype wire
